[rtl/mrt_pkg.sv]
package mrt_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned ENTRY_W   = 2 * ADDR_W;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } t_state;

endpackage

[rtl/mrt_ram.sv]
module mrt_ram #(
    parameter int unsigned WIDTH = mrt_pkg::ENTRY_W,
    parameter int unsigned DEPTH = mrt_pkg::DEPTH_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/masked_route_table_top.sv]
// compacted table of ipv4 address / mask pairs, valid entries always sit in slots
// 0 .. count-1 of a ram with one registered read port. one operation (add, delete,
// lookup) is taken at a time: o_in_ready is low in reset and from the accepted beat
// until the result has been handed to the output register. the sequencer scans the
// ram one entry per cycle and stops at the first match. a delete that hits a slot
// reads the last entry and writes it into the hole. an add of address zero, a delete
// of address zero and the unused mode skip the scan. the next beat can be taken in
// the cycle after the hand-over; a result register that is still full holds the
// hand-over back. the result register lets the next beat be accepted while a finished
// result still waits.
module masked_route_table_top #(
    parameter int unsigned TABLE_DEPTH = mrt_pkg::DEPTH_DEF,
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1),
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beat
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mrt_pkg::MODE_W-1:0]    i_mode,
    input  logic [mrt_pkg::ADDR_W-1:0]    i_address,
    input  logic [mrt_pkg::ADDR_W-1:0]    i_prefix_mask,
    // result beat
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mrt_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_route_found,
    output logic [CW-1:0]                 o_entry_count
);

    localparam int unsigned AW = mrt_pkg::ADDR_W;

    mrt_pkg::t_state r_state, n_state;

    // operation latched at the accepted beat
    logic [mrt_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [AW-1:0]                r_addr, n_addr;
    logic [AW-1:0]                r_mask, n_mask;

    // table occupancy
    logic [CW-1:0]                r_count, n_count;

    // scan pointers: r_idx is the read being issued, r_chk_idx the one whose data is back
    logic [CW-1:0]                r_idx, n_idx;
    logic [CW-1:0]                r_chk_idx, n_chk_idx;
    logic                         r_chk, n_chk;
    logic [IW-1:0]                r_hit_idx, n_hit_idx;

    // pending result
    logic [mrt_pkg::STATUS_W-1:0] r_status, n_status;
    logic                         r_found, n_found;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [mrt_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic                         r_out_found, n_out_found;
    logic [CW-1:0]                r_out_count, n_out_count;

    // ram port
    logic                         ram_wr_en;
    logic [IW-1:0]                ram_wr_addr;
    logic [mrt_pkg::ENTRY_W-1:0]  ram_wr_data;
    logic [IW-1:0]                ram_rd_addr;
    logic [mrt_pkg::ENTRY_W-1:0]  ram_rd_data;

    logic [AW-1:0]                ent_addr;
    logic [AW-1:0]                ent_mask;
    logic                         addr_eq;
    logic                         masked_eq;
    logic                         ent_match;
    logic [CW-1:0]                last_idx;

    mrt_ram #(
        .WIDTH (mrt_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // entry layout: address in the upper half, mask in the lower half
    assign ent_addr  = ram_rd_data[mrt_pkg::ENTRY_W-1:AW];
    assign ent_mask  = ram_rd_data[AW-1:0];
    assign addr_eq   = (ent_addr == r_addr);
    assign masked_eq = ((ent_mask & ent_addr) == (ent_mask & r_addr));
    assign last_idx  = r_count - 1'b1;

    // shared compare unit, the meaning of a hit depends on the operation
    always_comb begin
        case (r_mode)
            mrt_pkg::MODE_ADD:    ent_match = addr_eq | masked_eq;
            mrt_pkg::MODE_DELETE: ent_match = addr_eq;
            mrt_pkg::MODE_LOOKUP: ent_match = masked_eq;
            default:              ent_match = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrt_pkg::S_IDLE;
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_addr       <= n_addr;
        r_mask       <= n_mask;
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_hit_idx    <= n_hit_idx;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_addr       = r_addr;
        n_mask       = r_mask;
        n_count      = r_count;
        n_idx        = r_idx;
        n_chk_idx    = r_chk_idx;
        n_chk        = 1'b0;
        n_hit_idx    = r_hit_idx;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        o_in_ready   = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_hit_idx;
        ram_wr_data  = ram_rd_data;
        ram_rd_addr  = r_idx[IW-1:0];

        case (r_state)
            mrt_pkg::S_IDLE: begin
                // held low while in reset so no beat is taken and dropped
                o_in_ready = i_rst_n;
                n_idx      = '0;
                n_status   = mrt_pkg::ST_OK;
                n_found    = 1'b0;
                if (i_in_valid) begin
                    n_mode = i_mode;
                    n_addr = i_address;
                    n_mask = i_prefix_mask;
                    if (i_mode == mrt_pkg::MODE_DELETE && i_address == '0) begin
                        n_status = mrt_pkg::ST_NOT_FOUND;
                        n_state  = mrt_pkg::S_DONE;
                    end else if ((i_mode == mrt_pkg::MODE_ADD && i_address == '0) ||
                                 (i_mode != mrt_pkg::MODE_ADD &&
                                  i_mode != mrt_pkg::MODE_DELETE &&
                                  i_mode != mrt_pkg::MODE_LOOKUP)) begin
                        // ignored add and unused mode
                        n_state = mrt_pkg::S_DONE;
                    end else if (r_count == '0) begin
                        n_state = mrt_pkg::S_MISS;
                    end else begin
                        n_state = mrt_pkg::S_SCAN;
                    end
                end
            end

            mrt_pkg::S_SCAN: begin
                // issue the next read while the previous one is compared
                if (r_idx < r_count) begin
                    n_idx     = r_idx + 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx;
                end
                if (r_chk) begin
                    if (ent_match) begin
                        n_chk     = 1'b0;
                        n_hit_idx = r_chk_idx[IW-1:0];
                        case (r_mode)
                            mrt_pkg::MODE_DELETE: n_state = mrt_pkg::S_DEL_RD;
                            mrt_pkg::MODE_LOOKUP: begin
                                n_found = 1'b1;
                                n_state = mrt_pkg::S_DONE;
                            end
                            default: n_state = mrt_pkg::S_DONE;
                        endcase
                    end else if (r_chk_idx == last_idx) begin
                        n_chk   = 1'b0;
                        n_state = mrt_pkg::S_MISS;
                    end
                end
            end

            mrt_pkg::S_MISS: begin
                case (r_mode)
                    mrt_pkg::MODE_ADD: begin
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_status = mrt_pkg::ST_FULL;
                        end else begin
                            // append at the end of the compacted table
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = r_count[IW-1:0];
                            ram_wr_data = {r_addr, r_mask};
                            n_count     = r_count + 1'b1;
                        end
                    end
                    mrt_pkg::MODE_DELETE: n_status = mrt_pkg::ST_NOT_FOUND;
                    default:              n_found  = 1'b0;
                endcase
                n_state = mrt_pkg::S_DONE;
            end

            mrt_pkg::S_DEL_RD: begin
                // fetch the last entry to fill the hole
                ram_rd_addr = last_idx[IW-1:0];
                n_state     = mrt_pkg::S_DEL_WR;
            end

            mrt_pkg::S_DEL_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_hit_idx;
                ram_wr_data = ram_rd_data;
                n_count     = last_idx;
                n_state     = mrt_pkg::S_DONE;
            end

            mrt_pkg::S_DONE: begin
                // hand over once the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_count  = r_count;
                    n_state      = mrt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mrt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_route_found = r_out_found;
    assign o_entry_count = r_out_count;

endmodule
